// File: rtl/core/u8d_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the lead-byte classifier for the UTF-8 decoder.
// No dependencies; used by every module under rtl/core.
package u8d_pkg;

    localparam logic [7:0]  TEXT_BYTE_W = 8'd8;
    localparam logic [20:0] CP_QMARK    = 21'h00003F;

    // Lead byte classes, named by the length of the sequence they open
    typedef enum logic [2:0] {
        LEAD_ASCII = 3'd0,
        LEAD_TWO   = 3'd1,
        LEAD_THREE = 3'd2,
        LEAD_FOUR  = 3'd3,
        LEAD_BAD   = 3'd4
    } t_lead;

    // One queued decode job: up to four bytes, index of the last valid byte,
    // and whether the job closes the text
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            fin;
    } t_job;

    // Classify a byte as a lead
    function automatic t_lead lead_class(input logic [7:0] ch);
        t_lead cls;
        if (ch[7] == 1'b0) begin
            cls = LEAD_ASCII;
        end else if ((ch & 8'hE0) == 8'hC0) begin
            cls = LEAD_TWO;
        end else if ((ch & 8'hF0) == 8'hE0) begin
            cls = LEAD_THREE;
        end else if ((ch & 8'hF8) == 8'hF0) begin
            cls = LEAD_FOUR;
        end else begin
            cls = LEAD_BAD;
        end
        return cls;
    endfunction

    // Following-byte count of a lead class (zero for ASCII and bad leads)
    function automatic logic [1:0] follow_count(input t_lead cls);
        logic [1:0] cnt;
        case (cls)
            LEAD_TWO:   cnt = 2'd1;
            LEAD_THREE: cnt = 2'd2;
            LEAD_FOUR:  cnt = 2'd3;
            default:    cnt = 2'd0;
        endcase
        return cnt;
    endfunction

endpackage

// File: rtl/core/u8d_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes, gathers multi-byte sequences and issues decode jobs.
// Depends on u8d_pkg.
module u8d_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_fin,
    input  logic          i_q_ready,
    output logic          o_push,
    output u8d_pkg::t_job o_job
);
    import u8d_pkg::*;

    logic [2:0][7:0] r_held;
    logic [1:0]      r_cnt;
    logic [1:0]      r_need;
    logic [1:0]      n_cnt;
    logic [1:0]      n_need;
    logic            accept;
    logic            issue;
    logic            complete;
    t_lead           lead;
    logic [3:0][7:0] job_bytes;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign lead    = lead_class(i_byte);

    // Line up held bytes with the new byte behind them
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (k < 3 && 2'(k) < r_cnt) begin
                job_bytes[k] = r_held[k[1:0]];
            end else if (2'(k) == r_cnt) begin
                job_bytes[k] = i_byte;
            end else begin
                job_bytes[k] = 8'h00;
            end
        end
    end

    // A held sequence completes with the byte that is its last following byte
    assign complete = (r_cnt != 2'd0) && (r_cnt >= r_need);
    assign issue    = i_fin || complete ||
                      ((r_cnt == 2'd0) && (lead == LEAD_ASCII || lead == LEAD_BAD));
    assign o_push   = accept && issue;

    always_comb begin
        o_job.bytes    = job_bytes;
        o_job.last_idx = r_cnt;
        o_job.fin      = i_fin;
    end

    // Advance the gather count
    always_comb begin
        n_cnt  = r_cnt;
        n_need = r_need;
        if (accept) begin
            if (issue) begin
                n_cnt  = 2'd0;
                n_need = 2'd0;
            end else if (r_cnt == 2'd0) begin
                n_cnt  = 2'd1;
                n_need = follow_count(lead);
            end else begin
                n_cnt  = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_need <= 2'd0;
        end else begin
            r_cnt  <= n_cnt;
            r_need <= n_need;
        end
    end

    // Hold a byte that does not finish its sequence
    always_ff @(posedge i_clk) begin
        if (accept && !issue) begin
            r_held[r_cnt] <= i_byte;
        end
    end

endmodule

// File: rtl/core/u8d_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front and the back end of the UTF-8 decoder.
// Depends on u8d_pkg.
module u8d_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  u8d_pkg::t_job i_job,
    output logic          o_ready,
    output logic          o_valid,
    output u8d_pkg::t_job o_job,
    input  logic          i_pop
);
    import u8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Advance pointers with wrap at the queue depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // Store jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/core/u8d_back.sv
`timescale 1ns / 1ps
// Back end: walks queued jobs, a code point per cycle unless stalled.
// Depends on u8d_pkg.
module u8d_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  u8d_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [20:0]   o_code_point,
    output logic          o_text_done
);
    import u8d_pkg::*;

    logic [1:0]  r_pos;
    logic        r_ovalid;
    logic [20:0] r_cp;
    logic        r_done;
    logic        load;
    logic [7:0]  ch;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    t_lead       lead;
    logic        fits;
    logic [20:0] cp;
    logic [2:0]  adv;
    logic [2:0]  next_pos;
    logic        last_res;

    // Pick the lead at the walk position and the bytes behind it
    assign ch   = i_job.bytes[r_pos];
    assign b1   = i_job.bytes[r_pos + 2'd1];
    assign b2   = i_job.bytes[r_pos + 2'd2];
    assign b3   = i_job.bytes[r_pos + 2'd3];
    assign lead = lead_class(ch);
    assign fits = ({1'b0, r_pos} + {1'b0, follow_count(lead)}) <= {1'b0, i_job.last_idx};

    // Decode one code point
    always_comb begin
        cp  = CP_QMARK;
        adv = 3'd1;
        case (lead)
            LEAD_ASCII: begin
                cp = {13'd0, ch};
            end
            LEAD_TWO: begin
                if (fits) begin
                    cp  = {10'd0, ch[4:0], b1[5:0]};
                    adv = 3'd2;
                end
            end
            LEAD_THREE: begin
                if (fits) begin
                    cp  = {5'd0, ch[3:0], b1[5:0], b2[5:0]};
                    adv = 3'd3;
                end
            end
            LEAD_FOUR: begin
                if (fits) begin
                    cp  = {ch[2:0], b1[5:0], b2[5:0], b3[5:0]};
                    adv = 3'd4;
                end
            end
            default: begin
                cp  = CP_QMARK;
                adv = 3'd1;
            end
        endcase
    end

    assign next_pos = {1'b0, r_pos} + adv;
    assign last_res = next_pos > {1'b0, i_job.last_idx};
    assign load     = i_valid && (!r_ovalid || i_tready);
    assign o_pop    = load && last_res;

    // Load the output register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_pos    <= 2'd0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_pos    <= last_res ? 2'd0 : next_pos[1:0];
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= cp;
            r_done <= i_job.fin && last_res;
        end
    end

    assign o_tvalid     = r_ovalid;
    assign o_code_point = r_cp;
    assign o_text_done  = r_done;

    // Walk position stays inside the job
    a_pos_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (r_pos <= i_job.last_idx))
        else $error("walk position beyond last byte of job");

    // A job leaves the queue only together with its final result
    a_pop_with_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (load && last_res))
        else $error("job popped without final result");

    // Walk position returns to zero after a pop
    a_pos_reset_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_pos == 2'd0))
        else $error("walk position not cleared after pop");

    // Reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_tvalid)
        else $error("output valid after reset");

endmodule

// File: rtl/core/utf8_to_codepoint_decoder_top.sv
`timescale 1ns / 1ps
// UTF-8 to code point decoder, top level. Depends on u8d_pkg, u8d_front,
// u8d_queue and u8d_back.
// Throughput: one byte per cycle while the job queue has room; each byte
// gives zero or one code point, except a final byte that cuts a sequence
// short, which gives up to three, one per cycle from the back end's output
// register unless the output stalls. The job that completes a code point is
// registered in the job queue, and the code point in the back end's output
// register; the job queue holds QUEUE_DEPTH jobs.
// Reset: synchronous active low; clears the gather count, queue and output.
module utf8_to_codepoint_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    input  logic        i_s_axis_tlast,   // final_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        o_m_axis_tlast    // text_done
);
    import u8d_pkg::*;

    logic        push;
    t_job        push_job;
    logic        q_ready;
    logic        q_valid;
    t_job        head_job;
    logic        pop;
    logic [20:0] code_point;

    u8d_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata[TEXT_BYTE_W-1:0]),
        .i_fin     (i_s_axis_tlast),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_job     (push_job)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    u8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_tvalid     (o_m_axis_tvalid),
        .i_tready     (i_m_axis_tready),
        .o_code_point (code_point),
        .o_text_done  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'b000, code_point};

endmodule
